// ===== rtl/bsl_pkg.sv =====
// Shared types and constants for the BMP stream to LCD writer.
// Used by the front parser, the job queue, the back sequencer and the top level.
// No dependencies.
package bsl_pkg;

  // Panel geometry and image limit
  localparam int unsigned PANEL_WIDTH     = 128;
  localparam int unsigned PANEL_HEIGHT    = 160;
  localparam int unsigned MAX_IMAGE_WIDTH = 1280;

  // Job queue depth
  localparam int unsigned JOBQ_DEPTH = 4;
  localparam int unsigned JOBQ_AW    = 2;

  // Header layout
  localparam logic [5:0] HDR_LAST_POS = 6'd33;
  localparam logic [7:0] BPP_24       = 8'd24;

  // Panel register indexes
  localparam logic [15:0] REG_H_WINDOW = 16'h0044;
  localparam logic [15:0] REG_V_WINDOW = 16'h0045;
  localparam logic [15:0] REG_GRAM_ADR = 16'h0021;
  localparam logic [15:0] REG_GRAM_WR  = 16'h0022;

  // Configuration register indexes
  localparam logic CFG_COL_OFFSET = 1'b0;
  localparam logic CFG_ROW_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_FINISH = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SEEK   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_ROWS   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] col_offset;
    logic [7:0] row_offset;
  } cfg_t;

  // One job: all results caused by one input byte
  typedef struct packed {
    logic        reject;
    logic        hdr;
    logic        pix;
    logic        finish;
    logic [15:0] pix_word;
    logic [15:0] w_hwin;
    logic [15:0] w_vwin;
    logic [15:0] w_adr;
  } job_t;

endpackage

// ===== rtl/bsl_front.sv =====
// Front end: parses the BMP byte stream and turns each byte into a job.
// Depends on bsl_pkg.
module bsl_front import bsl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] byte_i,
  input  logic       sof_i,
  input  cfg_t       cfg_i,
  output job_t       job_o,
  output logic       push_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d, off_q, off_d, w_q, w_d, h_q, h_d, skip_q, skip_d;
  logic [4:0]  flags_q, flags_d;
  logic [7:0]  row_q, row_d;
  logic [8:0]  col_q, col_d;
  logic [11:0] bir_q, bir_d;
  logic [1:0]  sub_q, sub_d;
  logic [10:0] part_q, part_d;
  logic [8:0]  shown_q, shown_d;
  logic [7:0]  xs_q, xs_d, xe_q, xe_d, ys_q, ys_d, ye_q, ye_d;
  logic [11:0] pad_q, pad_d;

  // Geometry from the parsed header
  logic        w_big, h_big;
  logic [8:0]  pw9, ph9, shown_g, xe_sum, ye_sum;
  logic [7:0]  xs_g, xe_g, ys_g, ye_g;
  logic [12:0] w3;
  logic [11:0] pad_g;
  logic [31:0] skip_g;

  always_comb begin
    pw9     = 9'(PANEL_WIDTH);
    ph9     = 9'(PANEL_HEIGHT);
    w_big   = w_q > 32'(PANEL_WIDTH);
    h_big   = h_q > 32'(PANEL_HEIGHT);
    shown_g = w_big ? pw9 : w_q[8:0];
    xs_g    = w_big ? 8'd0 : 8'((pw9 - w_q[8:0]) >> 1);
    xe_sum  = {1'b0, xs_g} + shown_g - 9'd1;
    xe_g    = xe_sum[7:0];
    ys_g    = h_big ? 8'd0 : 8'((ph9 - h_q[8:0]) >> 1);
    ye_sum  = {1'b0, ys_g} + h_q[8:0] - 9'd1;
    ye_g    = h_big ? 8'(PANEL_HEIGHT - 1) : ye_sum[7:0];
    w3      = {1'b0, w_q[10:0], 1'b0} + {2'b00, w_q[10:0]} + 13'd3;
    pad_g   = {w3[11:2], 2'b00};
    skip_g  = h_big ? (h_q - 32'(PANEL_HEIGHT)) : 32'd0;
  end

  // Current view: a start mark restarts parsing on this byte
  phase_e      ph_c, dph;
  logic [31:0] pos_c, off_c, w_c, h_c;
  logic [4:0]  flags_c, flags_new;
  logic [5:0]  hp;
  logic        in_hdr, seek_hit, hdr_end, bad;
  logic [11:0] bir_c;
  logic [8:0]  col_c, col_inc;
  logic [1:0]  sub_c;
  logic [7:0]  row_c;
  logic        rows, row_start, in_cols, pix, fin, row_end;
  logic [12:0] bir_inc;

  always_comb begin
    ph_c     = sof_i ? PH_HEADER : phase_q;
    pos_c    = sof_i ? 32'd0 : pos_q;
    off_c    = sof_i ? 32'd0 : off_q;
    w_c      = sof_i ? 32'd0 : w_q;
    h_c      = sof_i ? 32'd0 : h_q;
    flags_c  = sof_i ? 5'd0 : flags_q;
    hp       = pos_c[5:0];
    in_hdr   = pos_c < 32'd34;
    seek_hit = (ph_c == PH_SEEK) && (pos_c >= off_q);
    dph      = seek_hit ? ((skip_q != 32'd0) ? PH_SKIP : PH_ROWS) : ph_c;
    bir_c    = seek_hit ? 12'd0 : bir_q;
    col_c    = seek_hit ? 9'd0 : col_q;
    sub_c    = seek_hit ? 2'd0 : sub_q;
    row_c    = seek_hit ? ye_q : row_q;

    // header field checks
    flags_new = flags_c;
    if (ph_c == PH_HEADER && in_hdr) begin
      case (hp)
        6'd26: if (byte_i != 8'd1) flags_new[0] = 1'b1;
        6'd27: if (byte_i != 8'd0) flags_new[1] = 1'b1;
        6'd28: if (byte_i != BPP_24) flags_new[2] = 1'b1;
        6'd29: if (byte_i != 8'd0) flags_new[3] = 1'b1;
        6'd30, 6'd31, 6'd32, 6'd33: if (byte_i != 8'd0) flags_new[4] = 1'b1;
        default: ;
      endcase
    end
    hdr_end = (ph_c == PH_HEADER) && (pos_c == 32'(HDR_LAST_POS));
    bad     = (flags_new != 5'd0) || (w_c == 32'd0) || (w_c > 32'(MAX_IMAGE_WIDTH))
              || (h_c == 32'd0);

    // pixel stream events
    rows      = dph == PH_ROWS;
    row_start = rows && (bir_c == 12'd0);
    in_cols   = rows && (col_c < shown_q);
    pix       = in_cols && (sub_c == 2'd2);
    col_inc   = col_c + 9'd1;
    fin       = pix && (col_inc == shown_q) && (row_c == ys_q);
    bir_inc   = {1'b0, bir_c} + 13'd1;
    row_end   = bir_inc >= {1'b0, pad_q};
  end

  // Next state
  always_comb begin
    phase_d = phase_q; pos_d = pos_q; off_d = off_q; w_d = w_q; h_d = h_q;
    flags_d = flags_q; skip_d = skip_q; row_d = row_q; col_d = col_q;
    bir_d = bir_q; sub_d = sub_q; part_d = part_q;
    shown_d = shown_q; xs_d = xs_q; xe_d = xe_q; ys_d = ys_q; ye_d = ye_q;
    pad_d = pad_q;
    if (acc_i) begin
      phase_d = dph;
      pos_d   = (pos_c == 32'hFFFF_FFFF) ? pos_c : pos_c + 32'd1;
      off_d   = off_c; w_d = w_c; h_d = h_c; flags_d = flags_new;
      bir_d   = bir_c; col_d = col_c; sub_d = sub_c; row_d = row_c;
      if (ph_c == PH_HEADER && in_hdr) begin
        case (hp)
          6'd10: off_d[7:0]   = byte_i;
          6'd11: off_d[15:8]  = byte_i;
          6'd12: off_d[23:16] = byte_i;
          6'd13: off_d[31:24] = byte_i;
          6'd18: w_d[7:0]     = byte_i;
          6'd19: w_d[15:8]    = byte_i;
          6'd20: w_d[23:16]   = byte_i;
          6'd21: w_d[31:24]   = byte_i;
          6'd22: h_d[7:0]     = byte_i;
          6'd23: h_d[15:8]    = byte_i;
          6'd24: h_d[23:16]   = byte_i;
          6'd25: h_d[31:24]   = byte_i;
          default: ;
        endcase
      end
      if (hdr_end) begin
        if (bad) begin
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_SEEK;
          skip_d  = skip_g;
          shown_d = shown_g; xs_d = xs_g; xe_d = xe_g;
          ys_d    = ys_g; ye_d = ye_g; pad_d = pad_g;
        end
      end
      // cropped rows are counted off
      if (dph == PH_SKIP) begin
        if (row_end) begin
          bir_d  = 12'd0;
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) phase_d = PH_ROWS;
        end else begin
          bir_d = bir_inc[11:0];
        end
      end
      // shown rows: pack B, G, R into RGB565
      if (rows) begin
        if (in_cols) begin
          case (sub_c)
            2'd0: begin
              part_d = {6'd0, byte_i[7:3]};
              sub_d  = 2'd1;
            end
            2'd1: begin
              part_d = {byte_i[7:2], part_q[4:0]};
              sub_d  = 2'd2;
            end
            default: begin
              col_d = col_inc;
              sub_d = 2'd0;
            end
          endcase
        end
        if (fin) begin
          phase_d = PH_IDLE;
        end else if (row_end) begin
          bir_d = 12'd0;
          col_d = 9'd0;
          sub_d = 2'd0;
          row_d = row_c - 8'd1;
        end else begin
          bir_d = bir_inc[11:0];
        end
      end
    end
  end

  // Job contents
  logic [8:0] xs_sum, xe_sum_c, r_sum;
  always_comb begin
    xs_sum   = {1'b0, cfg_i.col_offset} + {1'b0, xs_q};
    xe_sum_c = {1'b0, cfg_i.col_offset} + {1'b0, xe_q};
    r_sum    = {1'b0, cfg_i.row_offset} + {1'b0, row_c};
    job_o.reject   = hdr_end && bad;
    job_o.hdr      = row_start;
    job_o.pix      = pix;
    job_o.finish   = fin;
    job_o.pix_word = {byte_i[7:3], part_q};
    job_o.w_hwin   = {xe_sum_c[7:0], 8'd0} | {7'd0, xs_sum};
    job_o.w_vwin   = {r_sum[7:0], 8'd0} | {7'd0, r_sum};
    job_o.w_adr    = {r_sum[7:0], 8'd0} | {7'd0, xs_sum};
    push_o = acc_i && (job_o.reject || job_o.hdr || job_o.pix || job_o.finish);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; pos_q <= '0; off_q <= '0; w_q <= '0; h_q <= '0;
      flags_q <= '0; skip_q <= '0; row_q <= '0; col_q <= '0; bir_q <= '0;
      sub_q <= '0; part_q <= '0; shown_q <= '0; xs_q <= '0; xe_q <= '0;
      ys_q <= '0; ye_q <= '0; pad_q <= '0;
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; off_q <= off_d; w_q <= w_d; h_q <= h_d;
      flags_q <= flags_d; skip_q <= skip_d; row_q <= row_d; col_q <= col_d;
      bir_q <= bir_d; sub_q <= sub_d; part_q <= part_d; shown_q <= shown_d;
      xs_q <= xs_d; xe_q <= xe_d; ys_q <= ys_d; ye_q <= ye_d; pad_q <= pad_d;
    end
  end

endmodule

// ===== rtl/bsl_fifo.sv =====
// Job queue between the front parser and the back sequencer.
// Depends on bsl_pkg.
module bsl_fifo import bsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic valid_o,
  output logic full_o
);

  job_t                 mem_q [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_q, rd_q;
  logic [JOBQ_AW:0]     cnt_q, cnt_d;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == (JOBQ_AW + 1)'(JOBQ_DEPTH);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/bsl_back.sv =====
// Back end: expands each job into panel writes, one per cycle unless stalled, into an output register.
// Depends on bsl_pkg.
module bsl_back import bsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        job_i,
  input  logic        valid_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output kind_e       kind_o,
  output logic [15:0] value_o,
  output logic        last_o
);

  logic        out_valid_q, out_valid_d, last_q;
  kind_e       kind_q, kind_c;
  logic [15:0] value_q, value_c;
  logic        last_c, load;
  logic [3:0]  step_q, step_d, rel;

  // Select the result at the current step of the job
  always_comb begin
    rel     = job_i.hdr ? (step_q - 4'd7) : step_q;
    kind_c  = KIND_FINISH;
    value_c = 16'd0;
    last_c  = 1'b1;
    if (job_i.reject) begin
      kind_c = KIND_REJECT;
    end else if (job_i.hdr && step_q < 4'd7) begin
      last_c = (step_q == 4'd6) && !job_i.pix && !job_i.finish;
      case (step_q)
        4'd0: begin kind_c = KIND_CMD;  value_c = REG_H_WINDOW; end
        4'd1: begin kind_c = KIND_DATA; value_c = job_i.w_hwin; end
        4'd2: begin kind_c = KIND_CMD;  value_c = REG_V_WINDOW; end
        4'd3: begin kind_c = KIND_DATA; value_c = job_i.w_vwin; end
        4'd4: begin kind_c = KIND_CMD;  value_c = REG_GRAM_ADR; end
        4'd5: begin kind_c = KIND_DATA; value_c = job_i.w_adr;  end
        default: begin kind_c = KIND_CMD; value_c = REG_GRAM_WR; end
      endcase
    end else if (job_i.pix && rel == 4'd0) begin
      kind_c  = KIND_DATA;
      value_c = job_i.pix_word;
      last_c  = !job_i.finish;
    end
  end

  // Output register handshake
  always_comb begin
    load        = valid_i && (!out_valid_q || !out_stall_i);
    pop_o       = load && last_c;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = last_c ? 4'd0 : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
      kind_q      <= KIND_CMD;
      value_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      if (load) begin
        kind_q  <= kind_c;
        value_q <= value_c;
        last_q  <= last_c;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/bmp_stream_to_lcd_writer_unit.sv =====
// Top level of the BMP stream to LCD writer: front parser, job queue, back sequencer.
// Depends on bsl_pkg, bsl_front, bsl_fifo and bsl_back.
//
// Takes a 24-bit uncompressed BMP file one byte per transfer and produces panel
// command and data writes (RGB565) for a 128x160 panel, bottom row first. A byte is
// accepted every cycle while the four-entry job queue has room; a row's first byte
// makes seven writes and each pixel's third byte one (the top row's last pixel adds the
// finish result), drained one per cycle by the output register unless stalled. Rows of
// three or more pixels carry at least as many bytes as writes, so the input keeps one
// byte per cycle apart from short stalls behind row-start bursts; for images one or two
// pixels wide the input slows to the output rate. No clearing pass is needed after reset.
module bmp_stream_to_lcd_writer_unit import bsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  write_kind_o,
  output logic [15:0] bus_value_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t  cfg_q;
  job_t  job_in, job_out;
  logic  push, pop, q_valid, q_full, acc;
  kind_e kind;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COL_OFFSET: cfg_q.col_offset <= cfg_data_i;
        default:        cfg_q.row_offset <= cfg_data_i;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign acc        = in_valid_i && !in_stall_o;

  bsl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .byte_i (file_byte_i),
    .sof_i  (start_of_file_i),
    .cfg_i  (cfg_q),
    .job_o  (job_in),
    .push_o (push)
  );

  bsl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  bsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .valid_i     (q_valid),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind),
    .value_o     (bus_value_o),
    .last_o      (last_of_run_o)
  );

  assign write_kind_o = kind;

  // Checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full)) else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && !q_valid)) else $error("job popped from an empty queue");
  a_reject_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && job_in.reject) |-> (!job_in.hdr && !job_in.pix && !job_in.finish))
    else $error("reject job carries panel writes");
  a_finish_after_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && job_in.finish) |-> job_in.pix) else $error("finish without last pixel");

endmodule

// ===== verif/tb.sv =====
// Testbench for bmp_stream_to_lcd_writer_unit: BMP byte stream in, panel writes out.
// Depends on bsl_pkg and the RTL; a behavioral predictor checks every output transfer.
module tb;
  import bsl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] fbyte;
    logic       sof;
  } byte_item_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] value;
    logic        last;
  } write_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [7:0]  file_byte_i;
  logic        start_of_file_i;
  logic        out_valid_o, out_stall_i;
  logic [1:0]  write_kind_o;
  logic [15:0] bus_value_o;
  logic        last_of_run_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  bmp_stream_to_lcd_writer_unit u_dut (.*);

  // Clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  byte_item_t  pending_bytes[$];
  write_t      expected_writes[$];
  int          n_errors;
  int unsigned send_idle_pct, recv_stall_pct;
  bit          hold_recv;
  int          hold_cycles;
  longint      cycle_count;
  bit          in_taken;

  // Predictor state
  logic [7:0]  col_off_q, row_off_q;
  logic [31:0] pos_q, data_off_q, width_q, height_q, flags_q, skip_rows_q;
  logic [7:0]  panel_row_q;
  logic [11:0] col_q, row_byte_q;
  logic [15:0] colour_q;
  phase_e      phase_q;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic void push_write(input kind_e k, input logic [31:0] v);
    write_t w;
    w.kind  = k;
    w.value = v[15:0];
    w.last  = 1'b0;
    expected_writes.push_back(w);
  endfunction

  // Pixel-data byte handling for skip and row phases
  function automatic void predict_pixel_byte(input logic [7:0] b);
    logic [31:0] padded, shown, xs, xe, ys, r;
    logic [31:0] sub;
    padded = (width_q * 3 + 3) & ~32'd3;
    shown  = (width_q > PANEL_WIDTH) ? PANEL_WIDTH : width_q;
    xs     = (width_q > PANEL_WIDTH) ? 0 : (PANEL_WIDTH - width_q) / 2;
    xe     = xs + shown - 1;
    ys     = (height_q > PANEL_HEIGHT) ? 0 : (PANEL_HEIGHT - height_q) / 2;
    if (phase_q == PH_SKIP) begin
      row_byte_q++;
      if (32'(row_byte_q) >= padded) begin
        row_byte_q = 0;
        skip_rows_q--;
        if (skip_rows_q == 0) phase_q = PH_ROWS;
      end
      return;
    end
    if (row_byte_q == 0) begin
      xs = xs + col_off_q;
      xe = xe + col_off_q;
      r  = row_off_q + panel_row_q;
      push_write(KIND_CMD, REG_H_WINDOW);
      push_write(KIND_DATA, (xe << 8) | xs);
      push_write(KIND_CMD, REG_V_WINDOW);
      push_write(KIND_DATA, (r << 8) | r);
      push_write(KIND_CMD, REG_GRAM_ADR);
      push_write(KIND_DATA, (r << 8) | xs);
      push_write(KIND_CMD, REG_GRAM_WR);
    end
    if (32'(col_q) < shown) begin
      sub = 32'(row_byte_q) - 3 * 32'(col_q);
      if (sub == 0) colour_q = 16'(b >> 3);
      else if (sub == 1) colour_q |= 16'(b >> 2) << 5;
      else begin
        colour_q |= 16'(b >> 3) << 11;
        push_write(KIND_DATA, colour_q);
        col_q++;
        if (32'(col_q) == shown && 32'(panel_row_q) == ys) begin
          push_write(KIND_FINISH, 0);
          phase_q = PH_IDLE;
          return;
        end
      end
    end
    row_byte_q++;
    if (32'(row_byte_q) >= padded) begin
      row_byte_q  = 0;
      col_q       = 0;
      panel_row_q = panel_row_q - 1;
    end
  endfunction

  // Full per-byte prediction; marks the last write caused by the byte
  function automatic void predict_byte(input byte_item_t it);
    logic [31:0] p, yend;
    int          n0;
    n0 = expected_writes.size();
    if (it.sof) begin
      pos_q = 0; data_off_q = 0; width_q = 0; height_q = 0; flags_q = 0;
      skip_rows_q = 0; panel_row_q = 0; col_q = 0; row_byte_q = 0; colour_q = 0;
      phase_q = PH_HEADER;
    end
    p = pos_q;
    if (pos_q != '1) pos_q++;
    case (phase_q)
      PH_HEADER: begin
        if (p >= 10 && p <= 13) data_off_q |= 32'(it.fbyte) << (8 * (p - 10));
        else if (p >= 18 && p <= 21) width_q |= 32'(it.fbyte) << (8 * (p - 18));
        else if (p >= 22 && p <= 25) height_q |= 32'(it.fbyte) << (8 * (p - 22));
        else if (p == 26) begin if (it.fbyte != 1) flags_q |= 1; end
        else if (p == 27) begin if (it.fbyte != 0) flags_q |= 2; end
        else if (p == 28) begin if (it.fbyte != BPP_24) flags_q |= 4; end
        else if (p == 29) begin if (it.fbyte != 0) flags_q |= 8; end
        else if (p >= 30 && p <= 33) begin if (it.fbyte != 0) flags_q |= 16; end
        if (p == 33) begin
          if (flags_q != 0 || width_q == 0 || width_q > MAX_IMAGE_WIDTH || height_q == 0) begin
            push_write(KIND_REJECT, 0);
            phase_q = PH_IDLE;
          end else begin
            skip_rows_q = (height_q > PANEL_HEIGHT) ? height_q - PANEL_HEIGHT : 0;
            phase_q = PH_SEEK;
          end
        end
      end
      PH_SEEK: begin
        if (p >= data_off_q) begin
          row_byte_q = 0;
          col_q = 0;
          yend = (height_q > PANEL_HEIGHT) ? PANEL_HEIGHT - 1
                 : (PANEL_HEIGHT - height_q) / 2 + height_q - 1;
          panel_row_q = yend[7:0];
          phase_q = (skip_rows_q != 0) ? PH_SKIP : PH_ROWS;
          predict_pixel_byte(it.fbyte);
        end
      end
      PH_SKIP, PH_ROWS: predict_pixel_byte(it.fbyte);
      default: ;
    endcase
    if (expected_writes.size() > n0)
      expected_writes[expected_writes.size() - 1].last = 1'b1;
  endfunction

  // Stimulus builders
  function automatic void add_byte(input logic [7:0] b, input logic sof);
    byte_item_t it;
    it.fbyte = b;
    it.sof   = sof;
    pending_bytes.push_back(it);
  endfunction

  function automatic void add_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(v[8*i +: 8], 1'b0);
  endfunction

  // Header of 34 bytes, then pad to data offset, then random pixel data
  function automatic void add_bmp(input logic [31:0] w, input logic [31:0] h,
                                  input logic [31:0] doff, input int n_data,
                                  input logic [7:0] planes, input logic [7:0] bpp,
                                  input logic [7:0] comp);
    add_byte(8'h42, 1'b1);
    add_byte(8'h4d, 1'b0);
    for (int i = 2; i < 10; i++) add_byte(8'($urandom), 1'b0);
    add_le32(doff);
    for (int i = 14; i < 18; i++) add_byte(8'($urandom), 1'b0);
    add_le32(w);
    add_le32(h);
    add_byte(planes, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(bpp, 1'b0);
    add_byte(8'h00, 1'b0);
    add_le32({24'h0, comp});
    for (int i = 34; i < doff; i++) add_byte(8'($urandom), 1'b0);
    for (int i = 0; i < n_data; i++) add_byte(8'($urandom), 1'b0);
  endfunction

  function automatic int full_len(input int w, input int h);
    int shown_h;
    shown_h = (h > PANEL_HEIGHT) ? PANEL_HEIGHT : h;
    return ((w * 3 + 3) & ~3) * ((h - shown_h) + shown_h - 1) + 3 * ((w > 128) ? 128 : w);
  endfunction

  // Input driver: changes at falling edge, holds an offered byte until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_bytes.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid_i      <= 1'b1;
        file_byte_i     <= pending_bytes[0].fbyte;
        start_of_file_i <= pending_bytes[0].sof;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall
  always @(negedge clk_i) begin
    if (hold_recv) begin
      out_stall_i <= 1'b1;
      if (hold_cycles > 0) hold_cycles--;
      else hold_recv = 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Monitor and input acceptance at rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) predict_byte(pending_bytes.pop_front());
      if (out_valid_o && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write kind %0d value %h",
                                    write_kind_o, bus_value_o));
        end else begin
          write_t w;
          w = expected_writes.pop_front();
          if (write_kind_o !== w.kind || bus_value_o !== w.value ||
              last_of_run_o !== w.last)
            report_mismatch($sformatf("got %0d/%h/%b exp %0d/%h/%b",
                                      write_kind_o, bus_value_o, last_of_run_o,
                                      w.kind, w.value, w.last));
        end
      end
      if (cycle_count > 64'd2000000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_bytes.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_writes.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_COL_OFFSET) col_off_q = d;
    else row_off_q = d;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    n_errors = 0; cycle_count = 0; in_taken = 1'b0;
    hold_recv = 1'b0; hold_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    in_valid_i = 1'b0; file_byte_i = '0; start_of_file_i = 1'b0;
    out_stall_i = 1'b0; cfg_valid_i = 1'b0; cfg_index_i = 1'b0; cfg_data_i = '0;
    col_off_q = 0; row_off_q = 0; phase_q = PH_IDLE;
    pos_q = 0; data_off_q = 0; width_q = 0; height_q = 0; flags_q = 0;
    skip_rows_q = 0; panel_row_q = 0; col_q = 0; row_byte_q = 0; colour_q = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // No idling: stray bytes before any start, huge height with row skipping
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b0);
    add_bmp(1, 32'hffff_ffff, 34, 4, 1, BPP_24, 0);
    drain();

    // Sender idle: small valid image
    write_cfg(CFG_COL_OFFSET, 8'($urandom));
    write_cfg(CFG_ROW_OFFSET, 8'($urandom));
    send_idle_pct = 63;
    add_bmp(1, 2, 34, full_len(1, 2), 1, BPP_24, 0);
    drain();

    // Receiver stalling with a long hold; offsets carry into the upper byte
    write_cfg(CFG_COL_OFFSET, 8'hff);
    write_cfg(CFG_ROW_OFFSET, 8'hff);
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    hold_cycles    = 300;
    hold_recv      = 1'b1;
    add_bmp(2, 2, 10, full_len(2, 2), 1, BPP_24, 0);
    drain();

    // Both sides idle at times: bad header fields give a reject
    write_cfg(CFG_COL_OFFSET, 8'($urandom));
    write_cfg(CFG_ROW_OFFSET, 8'($urandom));
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    add_bmp(1, 1, 34, 0, 2, 8'd32, 1);
    drain();

    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
